[rtl/keypad_scan_number_entry_assert.svh]
// Assertion macros for the keypad scanner.
// Clock i_clk and active-low reset i_rst_n must be in scope where used.
`ifndef KEYPAD_SCAN_NUMBER_ENTRY_ASSERT_SVH
`define KEYPAD_SCAN_NUMBER_ENTRY_ASSERT_SVH
`ifndef SYNTHESIS
`define KPSNE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("keypad scanner check failed");
`define KPSNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner sequence check failed");
`else
`define KPSNE_ASSERT(lbl, prop)
`define KPSNE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/kpsne_pkg.sv]
package kpsne_pkg;

    localparam int unsigned DEBOUNCE_W     = 16;
    localparam int unsigned NUM_W          = 32;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    localparam logic [3:0] ALL_HIGH = 4'hF;
    localparam logic [3:0] ALL_LOW  = 4'h0;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CHAR_CONFIRM = 8'h4F;  // 'O'

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_SCAN     = 3'd2,
        PH_COLCHK   = 3'd3,
        PH_RELEASE  = 3'd4
    } t_phase;

    // Active-low pattern driving a single row low.
    function automatic logic [3:0] row_pattern(input logic [1:0] row);
        logic [3:0] pat;
        pat = ALL_HIGH;
        pat[row] = 1'b0;
        return pat;
    endfunction

    // 4x4 keypad legend.
    function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        case ({row, col})
            4'h0:    code = "1";
            4'h1:    code = "2";
            4'h2:    code = "3";
            4'h3:    code = "+";
            4'h4:    code = "4";
            4'h5:    code = "5";
            4'h6:    code = "6";
            4'h7:    code = "-";
            4'h8:    code = "7";
            4'h9:    code = "8";
            4'hA:    code = "9";
            4'hB:    code = "*";
            4'hC:    code = "C";
            4'hD:    code = "0";
            4'hE:    code = "O";
            4'hF:    code = "/";
            default: code = "/";
        endcase
        return code;
    endfunction

endpackage

[rtl/keypad_scan_number_entry.sv]
// A result is registered and presented in the cycle after its column sample is transferred in.
// Throughput: one sample per cycle; the output register frees as it is taken, so
//   a new sample is taken even while a result waits, unless output stall holds it full.
// Reset (synchronous, i_rst_n low): phase idle, accumulator 0, output empty,
//   debounce_ticks back to 20.
`include "keypad_scan_number_entry_assert.svh"

module keypad_scan_number_entry (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: debounce_ticks
    input  logic                               i_cfg_we,
    input  logic [kpsne_pkg::DEBOUNCE_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [3:0]                         i_column_levels,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [3:0]                         o_row_drive,
    output logic                               o_key_valid,
    output logic [7:0]                         o_key_code,
    output logic                               o_number_valid,
    output logic [kpsne_pkg::NUM_W-1:0]        o_number_value
);
    import kpsne_pkg::*;

    // control state
    t_phase                 r_phase, n_phase;
    logic [DEBOUNCE_W-1:0]  r_wait, n_wait;
    logic [1:0]             r_row, n_row;
    logic [NUM_W-1:0]       r_accum, n_accum;
    logic [DEBOUNCE_W-1:0]  r_debounce;

    // result register
    logic                   r_out_valid;
    logic [3:0]             r_row_drive;
    logic                   r_key_valid;
    logic [7:0]             r_key_code;
    logic                   r_number_valid;
    logic [NUM_W-1:0]       r_number_value;

    // combinational result of this sample
    logic [3:0]             drive;
    logic                   kv;
    logic [7:0]             kc;
    logic                   nv;
    logic [NUM_W-1:0]       nval;

    logic                   in_xfer;
    logic                   col_found;
    logic [1:0]             col_idx;
    logic [7:0]             key;
    logic                   key_is_digit;
    logic [3:0]             digit;
    logic [NUM_W-1:0]       accum_x10;

    // Output slot frees when empty or when its result transfers this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    // Lowest low column wins.
    always_comb begin
        col_found = 1'b1;
        col_idx   = 2'd0;
        if (!i_column_levels[0]) begin
            col_idx = 2'd0;
        end else if (!i_column_levels[1]) begin
            col_idx = 2'd1;
        end else if (!i_column_levels[2]) begin
            col_idx = 2'd2;
        end else if (!i_column_levels[3]) begin
            col_idx = 2'd3;
        end else begin
            col_found = 1'b0;
        end
    end

    assign key          = key_lookup(r_row, col_idx);
    assign key_is_digit = (key >= CHAR_ZERO) && (key <= CHAR_NINE);
    assign digit        = 4'(key - CHAR_ZERO);
    // x10 as shift-and-add
    assign accum_x10    = (r_accum << 3) + (r_accum << 1);

    // Next-state logic
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_row   = r_row;
        n_accum = r_accum;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (r_wait == '0) begin
                    n_row   = 2'd0;
                    n_phase = PH_SCAN;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            PH_SCAN: begin
                if (i_column_levels != ALL_HIGH) begin
                    n_phase = PH_COLCHK;
                end else if (r_row == 2'd3) begin
                    n_phase = PH_IDLE;   // no row answered
                end else begin
                    n_row = r_row + 2'd1;
                end
            end
            PH_COLCHK: begin
                if (!col_found) begin
                    n_phase = PH_IDLE;   // contact lost before column read
                end else begin
                    if (key_is_digit) begin
                        n_accum = accum_x10 + {{(NUM_W-4){1'b0}}, digit};
                    end else if (key == CHAR_CONFIRM) begin
                        n_accum = '0;
                    end
                    n_phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (i_column_levels == ALL_HIGH) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_column_levels != ALL_HIGH) begin
                    n_wait  = r_debounce;
                    n_phase = PH_DEBOUNCE;
                end
            end
        endcase
    end

    // Output logic
    always_comb begin
        drive = ALL_LOW;
        kv    = 1'b0;
        kc    = 8'h00;
        nv    = 1'b0;
        nval  = '0;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (r_wait == '0) begin
                    drive = row_pattern(2'd0);
                end
            end
            PH_SCAN: begin
                if (i_column_levels == ALL_HIGH && r_row != 2'd3) begin
                    drive = row_pattern(r_row + 2'd1);
                end
            end
            PH_COLCHK: begin
                if (col_found) begin
                    kv = 1'b1;
                    kc = key;
                    if (key == CHAR_CONFIRM) begin
                        nv   = 1'b1;
                        nval = r_accum;
                    end
                end
            end
            default: begin
                drive = ALL_LOW;
            end
        endcase
    end

    // State, config and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wait      <= '0;
            r_row       <= 2'd0;
            r_accum     <= '0;
            r_debounce  <= DEBOUNCE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_data;
            end
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_wait      <= n_wait;
                r_row       <= n_row;
                r_accum     <= n_accum;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_row_drive    <= drive;
            r_key_valid    <= kv;
            r_key_code     <= kc;
            r_number_valid <= nv;
            r_number_value <= nval;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_row_drive    = r_row_drive;
    assign o_key_valid    = r_key_valid;
    assign o_key_code     = r_key_code;
    assign o_number_valid = r_number_valid;
    assign o_number_value = r_number_value;

    // A reported key always comes with all rows driven low.
    `KPSNE_ASSERT(a_key_rows_low, (r_out_valid && r_key_valid) |-> (r_row_drive == ALL_LOW))
    // A number only leaves with the confirm key.
    `KPSNE_ASSERT(a_num_confirm, (r_out_valid && r_number_valid) |-> (r_key_valid && r_key_code == CHAR_CONFIRM))
    // Row drive is all low or exactly one row low.
    `KPSNE_ASSERT(a_drive_shape, r_out_valid |-> ((r_row_drive == ALL_LOW) || $onehot(~r_row_drive)))
    // Accumulator clears after a number goes out.
    `KPSNE_ASSERT_NEXT(a_accum_clr, in_xfer && r_phase == PH_COLCHK && col_found && key == CHAR_CONFIRM, r_accum == '0)
    // Nonzero debounce count keeps the block in debounce.
    `KPSNE_ASSERT_NEXT(a_debounce_hold, in_xfer && r_phase == PH_DEBOUNCE && r_wait != '0, r_phase == PH_DEBOUNCE)

endmodule
